// ----- src/assert_macros.svh -----
// Assertion macros used by the core RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
        else $error(msg);

`define ASSERT_IMPLIES(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
        else $error(msg);

`define ASSERT_NEXT(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rstn, cond, msg)
`define ASSERT_IMPLIES(label, clk, rstn, pre, post, msg)
`define ASSERT_NEXT(label, clk, rstn, pre, post, msg)

`endif

`endif

// ----- src/alrg_pkg.sv -----
// Types, constants and start table of the additive lagged generator.
`default_nettype none

package alrg_pkg;

    localparam int TABLE_LEN = 55;
    localparam int WRAP_LEN  = TABLE_LEN - 1;
    localparam int IDX_W     = $clog2(TABLE_LEN);
    localparam int WORD_W    = 32;
    localparam int MIX_W     = 10;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [WORD_W-1:0] word_t;
    typedef logic [MIX_W-1:0]  mix_t;

    localparam mix_t MIX_PREV      = 10'd1001;
    localparam mix_t MIX_SEED      = 10'd999;
    localparam idx_t SECOND_OFFSET = 6'o24;
    localparam idx_t LAST_IDX      = idx_t'(WRAP_LEN);
    localparam idx_t MIX_LAST_IDX  = idx_t'(WRAP_LEN - 1);

    // floor(n / 27) = (n * DIV_MAGIC) >> DIV_SHIFT for any n below 2^31
    localparam word_t DIV_MAGIC = 32'd2545165806;
    localparam int    DIV_SHIFT = 36;

    localparam logic CMD_DRAW   = 1'b0;
    localparam logic CMD_RESEED = 1'b1;

    typedef struct packed {
        logic  wr_en;
        idx_t  wr_addr;
        word_t wr_data;
        idx_t  rd_addr_a;
        idx_t  rd_addr_b;
    } tbl_req_t;

    function automatic word_t start_word(idx_t i);
        word_t w;
        case (i)
            6'd0:  w = 32'o35340171546;
            6'd1:  w = 32'o10401501101;
            6'd2:  w = 32'o22364657325;
            6'd3:  w = 32'o24130436022;
            6'd4:  w = 32'o02167303062;
            6'd5:  w = 32'o37570375137;
            6'd6:  w = 32'o37210607110;
            6'd7:  w = 32'o16272055420;
            6'd8:  w = 32'o23011770546;
            6'd9:  w = 32'o17143426366;
            6'd10: w = 32'o14753657433;
            6'd11: w = 32'o21657231332;
            6'd12: w = 32'o23553406142;
            6'd13: w = 32'o04236526362;
            6'd14: w = 32'o10365611275;
            6'd15: w = 32'o07117336710;
            6'd16: w = 32'o11051276551;
            6'd17: w = 32'o02362132524;
            6'd18: w = 32'o01011540233;
            6'd19: w = 32'o12162531646;
            6'd20: w = 32'o07056762337;
            6'd21: w = 32'o06631245521;
            6'd22: w = 32'o14164542224;
            6'd23: w = 32'o32633236305;
            6'd24: w = 32'o23342700176;
            6'd25: w = 32'o02433062234;
            6'd26: w = 32'o15257225043;
            6'd27: w = 32'o26762051606;
            6'd28: w = 32'o00742573230;
            6'd29: w = 32'o05366042132;
            6'd30: w = 32'o12126416411;
            6'd31: w = 32'o00520471171;
            6'd32: w = 32'o00725646277;
            6'd33: w = 32'o20116577576;
            6'd34: w = 32'o25765742604;
            6'd35: w = 32'o07633473735;
            6'd36: w = 32'o15674255275;
            6'd37: w = 32'o17555634041;
            6'd38: w = 32'o06503154145;
            6'd39: w = 32'o21576344247;
            6'd40: w = 32'o14577627653;
            6'd41: w = 32'o02707523333;
            6'd42: w = 32'o34146376720;
            6'd43: w = 32'o30060227734;
            6'd44: w = 32'o13765414060;
            6'd45: w = 32'o36072251540;
            6'd46: w = 32'o07255221037;
            6'd47: w = 32'o24364674123;
            6'd48: w = 32'o06200353166;
            6'd49: w = 32'o10126373326;
            6'd50: w = 32'o15664104320;
            6'd51: w = 32'o16401041535;
            6'd52: w = 32'o16215305520;
            6'd53: w = 32'o33115351014;
            6'd54: w = 32'o17411670323;
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- src/alrg_table.sv -----
// Lag table: two registered read ports, one write port, start values until written.
`default_nettype none

module alrg_table (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire alrg_pkg::tbl_req_t req,
    output alrg_pkg::word_t        rd_data_a,
    output alrg_pkg::word_t        rd_data_b
);
    import alrg_pkg::*;

    word_t                 lag_mem [TABLE_LEN];
    logic [TABLE_LEN-1:0]  vld_reg;
    word_t                 mem_a_reg;
    word_t                 mem_b_reg;
    logic                  vld_a_reg;
    logic                  vld_b_reg;
    idx_t                  idx_a_reg;
    idx_t                  idx_b_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            lag_mem[req.wr_addr] <= req.wr_data;
        end
        mem_a_reg <= lag_mem[req.rd_addr_a];
        mem_b_reg <= lag_mem[req.rd_addr_b];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (req.wr_en) begin
            vld_reg[req.wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        vld_a_reg <= vld_reg[req.rd_addr_a];
        vld_b_reg <= vld_reg[req.rd_addr_b];
        idx_a_reg <= req.rd_addr_a;
        idx_b_reg <= req.rd_addr_b;
    end

    assign rd_data_a = vld_a_reg ? mem_a_reg : start_word(idx_a_reg);
    assign rd_data_b = vld_b_reg ? mem_b_reg : start_word(idx_b_reg);

endmodule

`default_nettype wire

// ----- src/additive_lagged_random_generator_core.sv -----
// Top level of the additive lagged generator: sequencer, shared multiply-add, result register.
//
//   channel | ports             | direction | carries
//   --------+-------------------+-----------+------------------------------
//   input   | s_valid/s_ready   | in        | s_cmd (draw or reseed), s_seed
//   result  | m_valid/m_ready   | out       | m_value, one per draw
//
// A draw reads the table on both ports, then adds and writes back.
// A reseed reads and writes back word 0, then reads, mixes and writes back each of words
// 1 to 53 through the one table write port and the shared multiply-add unit, then does the
// reciprocal multiply, the mod 54 remainder of word 0 and the index placement.
// Reset is synchronous and active low; the table reads as its start values until written.
// A draw holds in write-back while the result register is full and m_ready is low.
`default_nettype none
`include "assert_macros.svh"

module additive_lagged_random_generator_core (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire logic            s_cmd,
    input  wire alrg_pkg::word_t s_seed,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output alrg_pkg::word_t      m_value
);
    import alrg_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DRAW_WB,
        ST_RS_READ,
        ST_RS_MUL,
        ST_RS_WRITE,
        ST_RS_DIV,
        ST_RS_MOD,
        ST_RS_PLACE
    } state_t;

    localparam logic [IDX_W:0] WRAP_WIDE = (IDX_W + 1)'(WRAP_LEN);

    state_t   state_reg,   state_next;
    idx_t     first_reg,   first_next;
    idx_t     second_reg,  second_next;
    idx_t     idx_reg,     idx_next;
    word_t    seed_reg,    seed_next;
    word_t    acc_reg,     acc_next;
    word_t    prev_reg,    prev_next;
    word_t    word0_reg,   word0_next;
    idx_t     quot_reg,    quot_next;
    idx_t     rem_reg,     rem_next;
    logic     m_valid_reg, m_valid_next;
    word_t    m_value_reg, m_value_next;

    tbl_req_t req;
    word_t    rd_data_a;
    word_t    rd_data_b;

    word_t                    mul_a;
    word_t                    mul_k;
    word_t                    mul_c;
    logic [2*WORD_W-1:0]      mul_prod;
    word_t                    mul_out;
    word_t                    add_b;
    word_t                    add_out;
    idx_t                     rem_calc;
    logic [IDX_W:0]           second_sum;
    idx_t                     second_calc;
    logic                     wb_go;
    logic                     draw_done;

    function automatic idx_t advance(idx_t p);
        return (p >= LAST_IDX) ? '0 : idx_t'(p + 1'b1);
    endfunction

    alrg_table u_table (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (req),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    assign mul_prod    = {{WORD_W{1'b0}}, mul_a} * {{WORD_W{1'b0}}, mul_k};
    assign mul_out     = mul_prod[WORD_W-1:0] + mul_c;
    assign add_out     = rd_data_a + add_b;
    assign rem_calc    = word0_reg[IDX_W-1:0] - idx_t'(quot_reg * LAST_IDX);
    assign second_sum  = {1'b0, rem_reg} + {1'b0, SECOND_OFFSET};
    assign second_calc = (second_sum >= WRAP_WIDE) ? idx_t'(second_sum - WRAP_WIDE)
                                                   : idx_t'(second_sum);
    assign wb_go       = !m_valid_reg || m_ready;
    assign draw_done   = (state_reg == ST_DRAW_WB) && wb_go;

    always_comb begin
        state_next   = state_reg;
        first_next   = first_reg;
        second_next  = second_reg;
        idx_next     = idx_reg;
        seed_next    = seed_reg;
        acc_next     = acc_reg;
        prev_next    = prev_reg;
        word0_next   = word0_reg;
        quot_next    = quot_reg;
        rem_next     = rem_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_value_next = m_value_reg;

        req.wr_en     = 1'b0;
        req.wr_addr   = first_reg;
        req.wr_data   = add_out;
        req.rd_addr_a = first_reg;
        req.rd_addr_b = second_reg;

        mul_a = prev_reg;
        mul_k = word_t'(MIX_PREV);
        mul_c = '0;
        add_b = rd_data_b;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_cmd == CMD_RESEED) begin
                        seed_next  = s_seed;
                        idx_next   = '0;
                        state_next = ST_RS_READ;
                    end else begin
                        state_next = ST_DRAW_WB;
                    end
                end
            end
            ST_DRAW_WB: begin
                if (draw_done) begin
                    req.wr_en    = 1'b1;
                    m_value_next = add_out;
                    m_valid_next = 1'b1;
                    first_next   = advance(first_reg);
                    second_next  = advance(second_reg);
                    state_next   = ST_IDLE;
                end
            end
            ST_RS_READ: begin
                req.rd_addr_a = idx_reg;
                acc_next      = mul_out;
                state_next    = (idx_reg == '0) ? ST_RS_WRITE : ST_RS_MUL;
            end
            ST_RS_MUL: begin
                req.rd_addr_a = idx_reg;
                mul_a         = seed_reg;
                mul_k         = word_t'(MIX_SEED);
                mul_c         = acc_reg;
                seed_next     = mul_out;
                state_next    = ST_RS_WRITE;
            end
            ST_RS_WRITE: begin
                req.rd_addr_a = idx_reg;
                req.wr_en     = 1'b1;
                req.wr_addr   = idx_reg;
                add_b         = seed_reg;
                prev_next     = add_out;
                if (idx_reg == '0) begin
                    word0_next = add_out;
                end
                if (idx_reg == MIX_LAST_IDX) begin
                    state_next = ST_RS_DIV;
                end else begin
                    idx_next   = idx_t'(idx_reg + 1'b1);
                    state_next = ST_RS_READ;
                end
            end
            ST_RS_DIV: begin
                mul_a      = word0_reg >> 1;
                mul_k      = DIV_MAGIC;
                quot_next  = mul_prod[DIV_SHIFT +: IDX_W];
                state_next = ST_RS_MOD;
            end
            ST_RS_MOD: begin
                rem_next   = rem_calc;
                state_next = ST_RS_PLACE;
            end
            ST_RS_PLACE: begin
                first_next  = rem_reg;
                second_next = second_calc;
                state_next  = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            first_reg   <= '0;
            second_reg  <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            first_reg   <= first_next;
            second_reg  <= second_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
        seed_reg    <= seed_next;
        acc_reg     <= acc_next;
        prev_reg    <= prev_next;
        word0_reg   <= word0_next;
        quot_reg    <= quot_next;
        rem_reg     <= rem_next;
        m_value_reg <= m_value_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_value = m_value_reg;

    `ASSERT_ALWAYS(a_first_range, aclk, aresetn, first_reg <= LAST_IDX, "first index out of range")
    `ASSERT_ALWAYS(a_second_range, aclk, aresetn, second_reg <= LAST_IDX, "second index out of range")
    `ASSERT_ALWAYS(a_mix_range, aclk, aresetn, idx_reg <= MIX_LAST_IDX, "reseed counter out of range")
    `ASSERT_IMPLIES(a_res_src, aclk, aresetn, $rose(m_valid_reg), $past(draw_done), "no draw")
    `ASSERT_NEXT(a_ptr_step, aclk, aresetn, draw_done, first_reg != $past(first_reg), "stuck")

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// Self-checking testbench for the additive lagged generator core.
`timescale 1ns / 1ps

module tb;

    import alrg_pkg::word_t;
    import alrg_pkg::CMD_DRAW;
    import alrg_pkg::CMD_RESEED;

    localparam int    WORDS        = 55;
    localparam int    WRAP_AT      = WORDS - 1;
    localparam int    TAP_GAP      = 20;
    localparam word_t MUL_PREV     = 32'd1001;
    localparam word_t MUL_SEED     = 32'd999;
    localparam int    HOLD_CYCLES  = 400;
    localparam int    DRAIN_CYCLES = 260;
    localparam int    STALL_LIMIT  = 5000;
    localparam int    MAX_REPORTS  = 10;

    logic  aclk;
    logic  aresetn;
    logic  s_valid;
    logic  s_ready;
    logic  s_cmd;
    word_t s_seed;
    logic  m_valid;
    logic  m_ready;
    word_t m_value;

    word_t lag_words [WORDS];
    int unsigned tap_a;
    int unsigned tap_b;
    word_t pending_draws [$];

    int  errors;
    int  reports;
    int  draws_sent;
    int  reseeds_sent;
    int  values_checked;
    int  holds_done;
    int  idle_cycles;
    bit  hold_req;

    additive_lagged_random_generator_core i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_cmd   (s_cmd),
        .s_seed  (s_seed),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_value (m_value)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic word_t boot_word(int idx);
        case (idx)
            0:  return 32'o35340171546;
            1:  return 32'o10401501101;
            2:  return 32'o22364657325;
            3:  return 32'o24130436022;
            4:  return 32'o02167303062;
            5:  return 32'o37570375137;
            6:  return 32'o37210607110;
            7:  return 32'o16272055420;
            8:  return 32'o23011770546;
            9:  return 32'o17143426366;
            10: return 32'o14753657433;
            11: return 32'o21657231332;
            12: return 32'o23553406142;
            13: return 32'o04236526362;
            14: return 32'o10365611275;
            15: return 32'o07117336710;
            16: return 32'o11051276551;
            17: return 32'o02362132524;
            18: return 32'o01011540233;
            19: return 32'o12162531646;
            20: return 32'o07056762337;
            21: return 32'o06631245521;
            22: return 32'o14164542224;
            23: return 32'o32633236305;
            24: return 32'o23342700176;
            25: return 32'o02433062234;
            26: return 32'o15257225043;
            27: return 32'o26762051606;
            28: return 32'o00742573230;
            29: return 32'o05366042132;
            30: return 32'o12126416411;
            31: return 32'o00520471171;
            32: return 32'o00725646277;
            33: return 32'o20116577576;
            34: return 32'o25765742604;
            35: return 32'o07633473735;
            36: return 32'o15674255275;
            37: return 32'o17555634041;
            38: return 32'o06503154145;
            39: return 32'o21576344247;
            40: return 32'o14577627653;
            41: return 32'o02707523333;
            42: return 32'o34146376720;
            43: return 32'o30060227734;
            44: return 32'o13765414060;
            45: return 32'o36072251540;
            46: return 32'o07255221037;
            47: return 32'o24364674123;
            48: return 32'o06200353166;
            49: return 32'o10126373326;
            50: return 32'o15664104320;
            51: return 32'o16401041535;
            52: return 32'o16215305520;
            53: return 32'o33115351014;
            54: return 32'o17411670323;
            default: return '0;
        endcase
    endfunction

    task automatic lag_reset();
        for (int i = 0; i < WORDS; i++) begin
            lag_words[i] = boot_word(i);
        end
        tap_a = 0;
        tap_b = 0;
    endtask

    function automatic int unsigned tap_step(int unsigned p);
        return (p >= WRAP_AT) ? 0 : p + 1;
    endfunction

    function automatic word_t lag_draw();
        word_t sum;
        sum = lag_words[tap_a] + lag_words[tap_b];
        lag_words[tap_a] = sum;
        tap_a = tap_step(tap_a);
        tap_b = tap_step(tap_b);
        return sum;
    endfunction

    task automatic lag_reseed(word_t seed_in);
        word_t mix;
        mix = seed_in;
        lag_words[0] = lag_words[0] + mix;
        for (int i = 1; i < WRAP_AT; i++) begin
            mix = lag_words[i-1] * MUL_PREV + mix * MUL_SEED;
            lag_words[i] = lag_words[i] + mix;
        end
        tap_a = lag_words[0] % WRAP_AT;
        tap_b = (tap_a + TAP_GAP) % WRAP_AT;
    endtask

    task automatic send_item(logic cmd, word_t seed);
        @(negedge aclk);
        s_valid <= 1'b1;
        s_cmd   <= cmd;
        s_seed  <= seed;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        if (cmd == CMD_DRAW) begin
            pending_draws.push_back(lag_draw());
            draws_sent++;
        end else begin
            lag_reseed(seed);
            reseeds_sent++;
        end
    endtask

    task automatic sender_gap(int cycles);
        if (cycles > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            s_cmd   <= 1'($urandom);
            s_seed  <= $urandom;
            repeat (cycles - 1) @(negedge aclk);
        end
    endtask

    function automatic word_t pick_seed();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return word_t'(1) << $urandom_range(0, 31);
            3: return ~(word_t'(1) << $urandom_range(0, 31));
            default: return $urandom;
        endcase
    endfunction

    // back-to-back draws from reset: both taps coincide, so each word doubles
    task automatic test_reset_draws();
        repeat (4) send_item(CMD_DRAW, '0);
    endtask

    task automatic test_reseed_extremes();
        send_item(CMD_RESEED, '0);
        send_item(CMD_DRAW, '1);
        send_item(CMD_DRAW, '0);
        send_item(CMD_RESEED, '1);
        send_item(CMD_DRAW, '0);
        send_item(CMD_DRAW, '0);
        send_item(CMD_RESEED, 32'h0000_0001);
        send_item(CMD_RESEED, 32'h8000_0000);
        send_item(CMD_DRAW, 32'h5555_5555);
        send_item(CMD_RESEED, 32'hAAAA_AAAA);
        send_item(CMD_DRAW, 32'hAAAA_AAAA);
        send_item(CMD_DRAW, '0);
    endtask

    task automatic test_backpressure();
        hold_req = 1'b1;
        for (int k = 0; k < 24; k++) begin
            send_item((k == 12) ? CMD_RESEED : CMD_DRAW, pick_seed());
        end
        while (hold_req) begin
            @(posedge aclk);
        end
    endtask

    task automatic test_random_traffic(int count);
        int burst;
        burst = 0;
        for (int k = 0; k < count; k++) begin
            if (burst == 0) begin
                sender_gap($urandom_range(1, 6));
                burst = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                    : $urandom_range(1, 16);
            end
            if ($urandom_range(0, 99) < 8) begin
                send_item(CMD_RESEED, pick_seed());
            end else begin
                send_item(CMD_DRAW, $urandom);
            end
            burst--;
        end
    endtask

    initial begin
        int mode;
        int mode_left;
        m_ready   = 1'b0;
        mode      = 0;
        mode_left = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
                holds_done++;
                hold_req = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom);
                    2: m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= (mode_left % 5 < 3);
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_draws.size() == 0) begin
                errors++;
                if (reports < MAX_REPORTS) begin
                    reports++;
                    $display("tb: unexpected transaction value=%08h at %0t", m_value, $time);
                end
            end else begin
                want = pending_draws.pop_front();
                values_checked++;
                if (m_value !== want) begin
                    errors++;
                    if (reports < MAX_REPORTS) begin
                        reports++;
                        $display("tb: value mismatch expected=%08h actual=%08h at %0t",
                                 want, m_value, $time);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: no transaction for %0d cycles", STALL_LIMIT);
            $display("tb: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        aclk           = 1'b0;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_cmd          = CMD_DRAW;
        s_seed         = '0;
        hold_req       = 1'b0;
        errors         = 0;
        reports        = 0;
        draws_sent     = 0;
        reseeds_sent   = 0;
        values_checked = 0;
        holds_done     = 0;
        idle_cycles    = 0;
        lag_reset();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_draws();
        test_reseed_extremes();
        test_backpressure();
        test_random_traffic(1750);

        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_draws.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_draws.size() != 0) begin
            errors++;
            $display("tb: %0d draws never returned", pending_draws.size());
        end

        $display("tb: %0d draws and %0d reseeds sent, %0d values checked, %0d errors",
                 draws_sent, reseeds_sent, values_checked, errors);
        $display("tb: %0d long receiver hold-offs with the input kept busy", holds_done);
        if (errors == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

// ----- additive_lagged_random_generator_core.f -----
+incdir+src
src/alrg_pkg.sv
src/alrg_table.sv
src/additive_lagged_random_generator_core.sv
test/tb.sv
